// ===== rtl/gmfp_pkg.sv =====
// ============================================================================
// gmfp_pkg - shared types and constants for the grid max-product block
// Cell and word widths, register map, direction codes, sequencer states.
// ============================================================================
package gmfp_pkg;

    // window length and the rows of history it needs
    localparam int RUN_LENGTH = 4;
    localparam int STORE_ROWS = RUN_LENGTH - 1;
    localparam int RD_IDX_W   = $clog2(RUN_LENGTH);

    // field widths
    localparam int CELL_W    = 7;
    localparam int PAIR_W    = 2 * CELL_W;
    localparam int PROD_W    = 4 * CELL_W;
    localparam int MAXPROD_W = 27;
    localparam int COORD_W   = 6;
    localparam int COLS_W    = 7;

    localparam logic [PROD_W-1:0]    PRODUCT_CAP = PROD_W'((2 ** MAXPROD_W) - 1);

    // default geometry
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // register map (word index = paddr[PADDR_W-1:2])
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_COLS_IN_USE = '0;
    localparam logic [COLS_W-1:0]  COLS_RESET      = COLS_W'(20);

    // one line-store entry: the column's cells for the three earlier rows,
    // element 0 is the most recent row
    typedef logic [STORE_ROWS-1:0][CELL_W-1:0] t_col_word;

    typedef enum logic [1:0] {
        DIR_RIGHT      = 2'd0,
        DIR_DOWN       = 2'd1,
        DIR_DOWN_LEFT  = 2'd2,
        DIR_DOWN_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GATHER,
        ST_MUL_PAIR,
        ST_MUL_FULL,
        ST_UPDATE,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/gmfp_prod4.sv =====
// ============================================================================
// gmfp_prod4 - two-stage product of four cells
// Stage one forms two pair products, stage two multiplies them.
// ============================================================================
module gmfp_prod4
    import gmfp_pkg::*;
(
    input  logic                        i_clk,
    input  logic [3:0][CELL_W-1:0]      i_factor,
    output logic [PROD_W-1:0]           o_product
);

    logic [PAIR_W-1:0] r_pair_lo;
    logic [PAIR_W-1:0] r_pair_hi;
    logic [PROD_W-1:0] r_product;

    always_ff @(posedge i_clk) begin
        r_pair_lo <= PAIR_W'(i_factor[0]) * PAIR_W'(i_factor[1]);
        r_pair_hi <= PAIR_W'(i_factor[2]) * PAIR_W'(i_factor[3]);
        r_product <= PROD_W'(r_pair_lo) * PROD_W'(r_pair_hi);
    end

    assign o_product = r_product;

endmodule

// ===== rtl/grid_max_four_cell_product.sv =====
// ============================================================================
// grid_max_four_cell_product - largest product of four adjacent grid cells
// Streams a raster grid and reports the best four-cell window on the last cell.
// ============================================================================
// Cells come in raster order, one word per input handshake, with last_cell
// set on the final cell of the grid. The row width is cols_in_use (register
// 0, clamped to 1..MAX_COLS). A line store of MAX_COLS entries, each holding
// one column's cells from the three previous rows, sits in a single-port-read
// synchronous RAM. Every cell closes up to four windows (right, down,
// down-left, down-right); the best product per direction and its origin are
// kept, and on the last cell one result word carries the overall best (a tie
// between directions goes to the later direction code), or all zero with
// found=0 when no window had a nonzero product. From accept to ready again,
// each input word passes the accept step, four RAM reads (columns c..c+3,
// one per cycle through the single read port), a gather step to land the
// last read, two multiply stages and an update/write-back step. The last
// cell adds a finish state to pick the winner and load the output register,
// and waits there while an earlier result is still held. The three columns
// left of the current one come from a small register window, not the RAM.
// The RAM needs no clearing after reset; input is taken right after reset.
// ============================================================================
module grid_max_four_cell_product
    import gmfp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // cell input
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CELL_W-1:0]       i_cell_value,
    input  logic                    i_last_cell,

    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [MAXPROD_W-1:0]    o_max_product,
    output logic [COORD_W-1:0]      o_origin_row,
    output logic [COORD_W-1:0]      o_origin_col,
    output logic [1:0]              o_direction,
    output logic                    o_found,

    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;  // column index
    localparam int CC_W  = $clog2(MAX_COLS + 1);                   // holds the width
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int WW    = ((CC_W > COLS_W) ? CC_W : COLS_W) + 1;  // compare width

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic [COLS_W-1:0] r_cols_in_use;
    logic              reg_wr;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_COLS_IN_USE);
    assign reg_wr  = psel & penable & pwrite & pready;
    assign prdata  = reg_hit ? PDATA_W'(r_cols_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= COLS_RESET;
        end else if (reg_wr && reg_hit) begin
            r_cols_in_use <= pwdata[COLS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [RD_IDX_W-1:0]  r_rd_idx;
    logic [CC_W-1:0]      r_col_count;
    logic [ROW_W-1:0]     r_row_count;
    logic [CC_W-1:0]      r_w;
    logic [CELL_W-1:0]    r_cell;
    logic                 r_last;

    t_col_word            r_words [RUN_LENGTH];   // columns c .. c+3 as read
    t_col_word            r_left  [STORE_ROWS];   // columns c-1 .. c-3, updated
    logic [CELL_W-1:0]    r_row_window [STORE_ROWS];

    logic [PROD_W-1:0]    r_best_prod [4];
    logic [ROW_W-1:0]     r_best_row  [4];
    logic [CI_W-1:0]      r_best_col  [4];

    logic                 r_out_valid;
    logic [MAXPROD_W-1:0] r_out_product;
    logic [COORD_W-1:0]   r_out_row;
    logic [COORD_W-1:0]   r_out_col;
    t_dir                 r_out_dir;
    logic                 r_out_found;

    // line store
    t_col_word            r_store [MAX_COLS];
    t_col_word            r_rd_data;
    logic [CI_W-1:0]      rd_addr;
    logic [WW-1:0]        rd_sum;
    t_col_word            new_word;
    logic                 mem_we;

    // control strobes
    logic                 accept;
    logic                 do_update;
    logic                 out_load;

    // ------------------------------------------------------------------
    // width clamp and position arithmetic
    // ------------------------------------------------------------------
    logic [WW-1:0]        cols_ext;
    logic [WW-1:0]        w_now_ext;
    logic [CC_W-1:0]      w_now;
    logic [ROW_W-1:0]     row_inc;
    logic [WW-1:0]        col_inc;
    logic [WW-1:0]        col_plus;

    always_comb begin
        cols_ext = WW'(r_cols_in_use);
        if (cols_ext == '0) begin
            w_now_ext = WW'(1);
        end else if (cols_ext > WW'(MAX_COLS)) begin
            w_now_ext = WW'(MAX_COLS);
        end else begin
            w_now_ext = cols_ext;
        end
        w_now = CC_W'(w_now_ext);
    end

    // row index sticks at the last row
    assign row_inc  = (r_row_count == ROW_W'(MAX_ROWS - 1)) ? r_row_count
                                                            : r_row_count + 1'b1;
    assign col_inc  = WW'(r_col_count) + WW'(1);
    assign col_plus = WW'(r_col_count) + WW'(STORE_ROWS);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        accept    = 1'b0;
        do_update = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_rd_idx == RD_IDX_W'(RUN_LENGTH - 1)) begin
                    n_state = ST_GATHER;
                end
            end
            ST_GATHER:   n_state = ST_MUL_PAIR;
            ST_MUL_PAIR: n_state = ST_MUL_FULL;
            ST_MUL_FULL: n_state = ST_UPDATE;
            ST_UPDATE: begin
                do_update = 1'b1;
                n_state   = r_last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign mem_we     = do_update;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (accept) begin
            r_rd_idx <= '0;
        end else if (r_state == ST_READ) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // line store RAM: reads c+k (clamped), write-back of column c
    // ------------------------------------------------------------------
    assign rd_sum  = WW'(r_col_count) + WW'(r_rd_idx);
    assign rd_addr = (rd_sum >= WW'(MAX_COLS)) ? CI_W'(MAX_COLS - 1) : CI_W'(rd_sum);

    // shift the column down one row and put the new cell on top
    assign new_word = {r_words[0][STORE_ROWS-2:0], r_cell};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_col_count[CI_W-1:0]] <= new_word;
        end
        r_rd_data <= r_store[rd_addr];
    end

    // read data lands in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_rd_idx != '0) begin
            r_words[r_rd_idx - 1'b1] <= r_rd_data;
        end else if (r_state == ST_GATHER) begin
            r_words[RUN_LENGTH-1] <= r_rd_data;
        end
    end

    // ------------------------------------------------------------------
    // input word and position
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell <= i_cell_value;
            r_last <= i_last_cell;
            r_w    <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (out_load) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (accept) begin
            // a width shrunk under the current column starts a new row
            if (r_col_count >= w_now) begin
                r_col_count <= '0;
                r_row_count <= row_inc;
            end
        end else if (do_update) begin
            if (col_inc >= WW'(r_w)) begin
                r_col_count <= '0;
                r_row_count <= row_inc;
            end else begin
                r_col_count <= CC_W'(col_inc);
            end
        end
    end

    // left columns: copies of the words just written back
    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_left[2] <= r_left[1];
            r_left[1] <= r_left[0];
            r_left[0] <= new_word;
        end
    end

    // cells falling out of the oldest row, used by down-right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            for (int i = 0; i < STORE_ROWS; i++) begin
                r_row_window[i] <= '0;
            end
        end else if (do_update) begin
            r_row_window[2] <= r_row_window[1];
            r_row_window[1] <= r_row_window[0];
            r_row_window[0] <= r_words[0][STORE_ROWS-1];
        end
    end

    // ------------------------------------------------------------------
    // window products, one two-stage unit per direction
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod [4];

    gmfp_prod4 u_prod_right (
        .i_clk     (i_clk),
        .i_factor  ({r_left[2][0], r_left[1][0], r_left[0][0], r_cell}),
        .o_product (prod[DIR_RIGHT])
    );

    gmfp_prod4 u_prod_down (
        .i_clk     (i_clk),
        .i_factor  ({r_words[0][2], r_words[0][1], r_words[0][0], r_cell}),
        .o_product (prod[DIR_DOWN])
    );

    gmfp_prod4 u_prod_down_left (
        .i_clk     (i_clk),
        .i_factor  ({r_words[3][2], r_words[2][1], r_words[1][0], r_cell}),
        .o_product (prod[DIR_DOWN_LEFT])
    );

    gmfp_prod4 u_prod_down_right (
        .i_clk     (i_clk),
        .i_factor  ({r_left[1][2], r_left[0][1], r_row_window[2], r_cell}),
        .o_product (prod[DIR_DOWN_RIGHT])
    );

    // which windows exist at this cell, and where they start
    logic             col_ge;
    logic             row_ge;
    logic             dl_fits;
    logic             cand_ok  [4];
    logic [ROW_W-1:0] cand_row [4];
    logic [CI_W-1:0]  cand_col [4];
    logic [ROW_W-1:0] row_up;
    logic [CI_W-1:0]  col_back;

    assign col_ge   = (WW'(r_col_count) >= WW'(STORE_ROWS));
    assign row_ge   = ((ROW_W + 1)'(r_row_count) >= (ROW_W + 1)'(STORE_ROWS));
    assign dl_fits  = (col_plus < WW'(r_w));
    assign row_up   = r_row_count - ROW_W'(STORE_ROWS);
    assign col_back = CI_W'(WW'(r_col_count) - WW'(STORE_ROWS));

    always_comb begin
        cand_ok[DIR_RIGHT]       = col_ge;
        cand_row[DIR_RIGHT]      = r_row_count;
        cand_col[DIR_RIGHT]      = col_back;

        cand_ok[DIR_DOWN]        = row_ge;
        cand_row[DIR_DOWN]       = row_up;
        cand_col[DIR_DOWN]       = r_col_count[CI_W-1:0];

        // down-left origin is the top-right cell
        cand_ok[DIR_DOWN_LEFT]   = row_ge && dl_fits;
        cand_row[DIR_DOWN_LEFT]  = row_up;
        cand_col[DIR_DOWN_LEFT]  = CI_W'(col_plus);

        cand_ok[DIR_DOWN_RIGHT]  = row_ge && col_ge;
        cand_row[DIR_DOWN_RIGHT] = row_up;
        cand_col[DIR_DOWN_RIGHT] = col_back;
    end

    // per-direction best, first strictly larger wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            for (int d = 0; d < 4; d++) begin
                r_best_prod[d] <= '0;
                r_best_row[d]  <= '0;
                r_best_col[d]  <= '0;
            end
        end else if (do_update) begin
            for (int d = 0; d < 4; d++) begin
                if (cand_ok[d] && (prod[d] > r_best_prod[d])) begin
                    r_best_prod[d] <= prod[d];
                    r_best_row[d]  <= cand_row[d];
                    r_best_col[d]  <= cand_col[d];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // final pick: pairwise tree, ties to the later direction
    // ------------------------------------------------------------------
    t_dir                    sel_a, sel_b, win;
    logic [PROD_W-1:0]       val_a, val_b, best_val;
    logic [ROW_W+COORD_W-1:0] row_ext;
    logic [CI_W+COORD_W-1:0]  col_ext;

    always_comb begin
        if (r_best_prod[DIR_DOWN] >= r_best_prod[DIR_RIGHT]) begin
            sel_a = DIR_DOWN;
        end else begin
            sel_a = DIR_RIGHT;
        end
        if (r_best_prod[DIR_DOWN_RIGHT] >= r_best_prod[DIR_DOWN_LEFT]) begin
            sel_b = DIR_DOWN_RIGHT;
        end else begin
            sel_b = DIR_DOWN_LEFT;
        end
        val_a = r_best_prod[sel_a];
        val_b = r_best_prod[sel_b];
        if (val_b >= val_a) begin
            win      = sel_b;
            best_val = val_b;
        end else begin
            win      = sel_a;
            best_val = val_a;
        end
        row_ext = (ROW_W + COORD_W)'(r_best_row[win]);
        col_ext = (CI_W + COORD_W)'(r_best_col[win]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (best_val == '0) begin
                r_out_product <= '0;
                r_out_row     <= '0;
                r_out_col     <= '0;
                r_out_dir     <= DIR_RIGHT;
                r_out_found   <= 1'b0;
            end else begin
                r_out_product <= (best_val > PRODUCT_CAP) ? PRODUCT_CAP[MAXPROD_W-1:0]
                                                          : best_val[MAXPROD_W-1:0];
                r_out_row     <= row_ext[COORD_W-1:0];
                r_out_col     <= col_ext[COORD_W-1:0];
                r_out_dir     <= win;
                r_out_found   <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_max_product = r_out_product;
    assign o_origin_row  = r_out_row;
    assign o_origin_col  = r_out_col;
    assign o_direction   = r_out_dir;
    assign o_found       = r_out_found;

endmodule

// ===== tb/gmfp_checker.sv =====
// ============================================================================
// gmfp_checker - scoreboard for the grid max-product block
// Follows the cell, result and register traffic, predicts each result word
// from its own model of the grid scan, and counts field mismatches.
// ============================================================================
module gmfp_checker
    import gmfp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [CELL_W-1:0]       i_cell_value,
    input  logic                    i_last_cell,

    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [MAXPROD_W-1:0]    i_max_product,
    input  logic [COORD_W-1:0]      i_origin_row,
    input  logic [COORD_W-1:0]      i_origin_col,
    input  logic [1:0]              i_direction,
    input  logic                    i_found,

    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic                    i_pready,
    input  logic [PADDR_W-1:0]      i_paddr,
    input  logic [PDATA_W-1:0]      i_pwdata,

    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct {
        logic [MAXPROD_W-1:0] product;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        t_dir                 dir;
        logic                 found;
    } t_best_window;

    // model state
    logic [CELL_W-1:0]  line_mem [STORE_ROWS][MAX_COLS];
    logic [CELL_W-1:0]  left_win [STORE_ROWS];
    int                 row_idx;
    int                 col_idx;
    logic [63:0]        best_prod [4];
    logic [COORD_W-1:0] best_row [4];
    logic [COORD_W-1:0] best_col [4];
    logic [COLS_W-1:0]  cols_reg;

    t_best_window       expected_best [$];
    t_best_window       want_word;
    int                 fails = 0;
    int                 waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic logic [63:0] line_at(input int back, input int col);
        if (back >= STORE_ROWS || col >= MAX_COLS)
            return 64'd0;
        return 64'(line_mem[back][col]);
    endfunction

    task automatic clear_grid();
        row_idx = 0;
        col_idx = 0;
        for (int j = 0; j < STORE_ROWS; j++)
            left_win[j] = '0;
        for (int d = 0; d < 4; d++) begin
            best_prod[d] = '0;
            best_row[d]  = '0;
            best_col[d]  = '0;
        end
    endtask

    task automatic step_row();
        col_idx = 0;
        if (row_idx < MAX_ROWS - 1)
            row_idx++;
    endtask

    // first strictly larger product wins within a direction
    task automatic keep(input t_dir dir, input int r, input int c, input logic [63:0] p);
        if (p > best_prod[dir]) begin
            best_prod[dir] = p;
            best_row[dir]  = COORD_W'(r);
            best_col[dir]  = COORD_W'(c);
        end
    endtask

    task automatic absorb_cell(input logic [CELL_W-1:0] cell_in, input logic last_in);
        int           w;
        int           r;
        int           c;
        logic [63:0]  p;
        logic [63:0]  top;
        logic [CELL_W-1:0] dropped;
        t_dir         win;
        t_best_window res;

        w = int'(cols_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_COLS)
            w = MAX_COLS;
        if (col_idx >= w)
            step_row();
        r = row_idx;
        c = col_idx;

        if (c >= RUN_LENGTH - 1) begin
            p = 64'(cell_in) * line_at(0, c - 1) * line_at(0, c - 2) * line_at(0, c - 3);
            keep(DIR_RIGHT, r, c - 3, p);
        end
        if (r >= RUN_LENGTH - 1) begin
            p = 64'(cell_in) * line_at(0, c) * line_at(1, c) * line_at(2, c);
            keep(DIR_DOWN, r - 3, c, p);
            if (c + 3 < w) begin
                p = 64'(cell_in) * line_at(0, c + 1) * line_at(1, c + 2)
                    * line_at(2, c + 3);
                keep(DIR_DOWN_LEFT, r - 3, c + 3, p);
            end
            if (c >= RUN_LENGTH - 1) begin
                p = 64'(cell_in) * 64'(left_win[STORE_ROWS-1])
                    * line_at(1, c - 1) * line_at(2, c - 2);
                keep(DIR_DOWN_RIGHT, r - 3, c - 3, p);
            end
        end

        // column shift; the oldest cell moves into the left window
        dropped = line_mem[STORE_ROWS-1][c];
        for (int j = STORE_ROWS - 1; j > 0; j--) begin
            line_mem[j][c] = line_mem[j-1][c];
            left_win[j]    = left_win[j-1];
        end
        line_mem[0][c] = cell_in;
        left_win[0]    = dropped;

        col_idx++;
        if (col_idx >= w)
            step_row();

        if (last_in) begin
            top = '0;
            win = DIR_RIGHT;
            for (int d = 0; d < 4; d++) begin
                if (best_prod[d] >= top) begin
                    top = best_prod[d];
                    win = t_dir'(d);
                end
            end
            if (top == 0) begin
                res.product = '0;
                res.row     = '0;
                res.col     = '0;
                res.dir     = DIR_RIGHT;
                res.found   = 1'b0;
            end else begin
                res.product = (top > 64'(PRODUCT_CAP)) ? MAXPROD_W'(PRODUCT_CAP)
                                                       : top[MAXPROD_W-1:0];
                res.row     = best_row[win];
                res.col     = best_col[win];
                res.dir     = win;
                res.found   = 1'b1;
            end
            expected_best.insert(expected_best.size(), res);
            clear_grid();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STORE_ROWS; j++)
                for (int k = 0; k < MAX_COLS; k++)
                    line_mem[j][k] = '0;
            cols_reg = COLS_RESET;
            clear_grid();
            expected_best.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[PADDR_W-1:2] == REG_COLS_IN_USE)
                cols_reg = i_pwdata[COLS_W-1:0];

            if (i_out_valid && i_out_ready) begin
                if (expected_best.size() == 0) begin
                    $display("%0t: unexpected result: product %0d row %0d col %0d",
                             $time, i_max_product, i_origin_row, i_origin_col);
                    fails++;
                end else begin
                    want_word = expected_best.pop_front();
                    check_field("max_product", 32'(want_word.product), 32'(i_max_product));
                    check_field("origin_row", 32'(want_word.row), 32'(i_origin_row));
                    check_field("origin_col", 32'(want_word.col), 32'(i_origin_col));
                    check_field("direction", 32'(want_word.dir), 32'(i_direction));
                    check_field("found", 32'(want_word.found), 32'(i_found));
                end
            end

            if (i_in_valid && i_in_ready)
                absorb_cell(i_cell_value, i_last_cell);
        end
        waiting = expected_best.size();
    end

endmodule

// ===== tb/tb_grid_max_four_cell_product.sv =====
// ============================================================================
// tb_grid_max_four_cell_product - testbench top for the grid max-product block
// Drives cell words and register writes, paces the result side, and reports
// the verdict from the checker's mismatch count.
// ============================================================================
// Flow: one reset, a short directed block (lone cell, saturating window,
// all-equal grid for direction ties, width cut mid-grid), then three random
// sections with different idle mixes. Each random section is a series of
// register settings; under each setting whole grids of random size are
// streamed, mostly narrow ones so that many result words come back. Widths
// outside 4..64 are written too, and one tall grid runs past the row limit.
// The width register is only touched when no result word is outstanding
// and the block has had time to finish the word in flight.
// ============================================================================
module tb_grid_max_four_cell_product;
    import gmfp_pkg::*;

    localparam int HOLD_CYCLES   = 600;  // long receiver stall, fills the block
    localparam int SETTLE_CYCLES = 16;   // covers one word's pass through the block plus the finish state
    localparam int DRAIN_CYCLES  = 32;
    localparam int MODE_ITEMS    = 250;
    localparam int PHASE_ITEMS   = 60;
    localparam int TALL_ROWS     = 68;   // past the 64-row limit

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [CELL_W-1:0]      i_cell_value;
    logic                   i_last_cell;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [MAXPROD_W-1:0]   o_max_product;
    logic [COORD_W-1:0]     o_origin_row;
    logic [COORD_W-1:0]     o_origin_col;
    logic [1:0]             o_direction;
    logic                   o_found;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int fail_count;
    int pending;

    // pacing knobs, percent of cycles spent idle
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_wanted;
    bit hold_done;

    int phase_no;
    bit tall_done;
    int mode_items;
    int phase_items;
    int grid_cells;
    int cols;
    int weff;

    // the first settings of the random part: range edges and clamped values
    int extreme_cols [8] = '{64, 4, 127, 0, 1, 3, 65, 2};

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    grid_max_four_cell_product u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_value  (i_cell_value),
        .i_last_cell   (i_last_cell),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_max_product (o_max_product),
        .o_origin_row  (o_origin_row),
        .o_origin_col  (o_origin_col),
        .o_direction   (o_direction),
        .o_found       (o_found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    gmfp_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cell_value  (i_cell_value),
        .i_last_cell   (i_last_cell),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_max_product (o_max_product),
        .i_origin_row  (o_origin_row),
        .i_origin_col  (o_origin_col),
        .i_direction   (o_direction),
        .i_found       (o_found),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // hard stop, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("grid_max_four_cell_product: mismatch");
        $finish;
    end

    // result side: random backpressure, plus one long hold-off counted here
    initial begin
        i_out_ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_wanted && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // mostly in-range values, with zeros, large ones and 100..127
    function automatic logic [CELL_W-1:0] random_cell();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '0;
        if (pick < 16)
            return CELL_W'($urandom_range(100, 127));
        if (pick < 30)
            return CELL_W'($urandom_range(90, 99));
        return CELL_W'($urandom_range(0, 99));
    endfunction

    function automatic int pick_cols();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(4, 8);
        if (pick < 85)
            return $urandom_range(9, 24);
        return $urandom_range(25, 64);
    endfunction

    // one cell word; returns at the falling edge after it was taken
    task automatic send_cell(input logic [CELL_W-1:0] val, input logic last_in);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_value <= val;
        i_last_cell  <= last_in;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // no result outstanding, then let the word in flight finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup then access phase; upper data bits are don't-care noise
    task automatic write_cols(input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COLS_IN_USE, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF80) | (32'(val) & 32'h7F);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one grid at the current width: full rows or a cut last row
    task automatic send_grid(input int w_eff, input bit tall, output int n_sent);
        int rows;
        int n_cells;
        int row;
        logic [CELL_W-1:0] val;

        if (tall)
            rows = TALL_ROWS;
        else if (w_eff < 4)
            rows = $urandom_range(1, 12);
        else if (w_eff <= 8)
            rows = $urandom_range(1, 8);
        else if (w_eff <= 24)
            rows = $urandom_range(1, 6);
        else
            rows = $urandom_range(1, 4);

        n_cells = rows * w_eff;
        if (!tall && $urandom_range(0, 1))
            n_cells -= $urandom_range(0, w_eff - 1);

        for (int i = 0; i < n_cells; i++) begin
            row = i / w_eff;
            // tall grid: large values only from row 60 on, near and past the row limit
            if (tall)
                val = (row < 60) ? CELL_W'($urandom_range(0, 2))
                                 : CELL_W'($urandom_range(50, 99));
            else
                val = random_cell();
            send_cell(val, i == n_cells - 1);
        end
        n_sent = n_cells;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cell_value = '0;
        i_last_cell  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        snd_idle_pct = 12;
        rcv_idle_pct = 78;
        hold_wanted  = 1'b0;
        phase_no     = 0;
        tall_done    = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // width 20 out of reset, a lone last cell: no window fits
        send_cell(7'd99, 1'b1);

        // four max-code cells in a row: product saturates
        wait_idle();
        write_cols(4);
        repeat (3) send_cell(7'd127, 1'b0);
        send_cell(7'd127, 1'b1);

        // 4x4 of ones: every direction ties, the last direction code wins,
        // and within a direction the first window stays
        for (int i = 0; i < 16; i++)
            send_cell(7'd1, i == 15);

        // width cut below the current column mid-grid: next cell opens a row
        wait_idle();
        write_cols(20);
        send_cell(7'd0, 1'b0);
        send_cell(7'd127, 1'b0);
        send_cell(7'd50, 1'b0);
        send_cell(7'd99, 1'b0);
        send_cell(7'd3, 1'b0);
        send_cell(7'd64, 1'b0);
        wait_idle();
        write_cols(4);
        send_cell(7'd88, 1'b0);
        send_cell(7'd1, 1'b1);

        // ---- random ----
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    snd_idle_pct = 12;
                    rcv_idle_pct = 78;
                end
                1: begin
                    snd_idle_pct = 78;
                    rcv_idle_pct = 12;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase

            mode_items = 0;
            while (mode_items < MODE_ITEMS) begin
                cols = (phase_no < 8) ? extreme_cols[phase_no] : pick_cols();
                phase_no++;
                // every setting change doubles as a full drain of the block
                wait_idle();
                write_cols(cols);
                // sender keeps offering while the result side is held
                if (mode == 2)
                    hold_wanted = 1'b1;
                weff = (cols < 1) ? 1 : (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols;

                phase_items = 0;
                while (phase_items < PHASE_ITEMS) begin
                    send_grid(weff, !tall_done && weff == 4, grid_cells);
                    if (weff == 4)
                        tall_done = 1'b1;
                    phase_items += grid_cells;
                end
                mode_items += phase_items;
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("grid_max_four_cell_product: match");
        else
            $display("grid_max_four_cell_product: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gmfp_pkg.sv
rtl/gmfp_prod4.sv
rtl/grid_max_four_cell_product.sv
tb/gmfp_checker.sv
tb/tb_grid_max_four_cell_product.sv
